>>> rtl/aip_pkg.sv
`default_nettype none

package aip_pkg;

   localparam int CHAR_W  = 8;
   localparam int RADIX_W = 5;
   localparam int VALUE_W = 64;
   localparam int POS_W   = 10;
   localparam int DIGIT_W = 4;

   localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
   localparam logic [CHAR_W-1:0]  CHAR_NUL    = 8'h00;

   typedef struct packed {
      logic               hex;   // byte is 0-9, A-F or a-f
      logic [DIGIT_W-1:0] val;
   } digit_type;

   typedef struct packed {
      logic [POS_W-1:0]   pos;
      logic               failed;
      logic [VALUE_W-1:0] value;
   } rsp_type;

   function automatic digit_type digit_of(input logic [CHAR_W-1:0] c);
      digit_type d;
      logic [CHAR_W-1:0] t;
      d = '0;
      t = '0;
      case (c) inside
         [8'h30:8'h39]: begin
            t     = c - 8'h30;
            d.hex = 1'b1;
         end
         [8'h41:8'h46]: begin
            t     = c - 8'h37;
            d.hex = 1'b1;
         end
         [8'h61:8'h66]: begin
            t     = c - 8'h57;
            d.hex = 1'b1;
         end
         default: begin
            t     = '0;
            d.hex = 1'b0;
         end
      endcase
      d.val = t[DIGIT_W-1:0];
      return d;
   endfunction

endpackage

`default_nettype wire

>>> rtl/ascii_integer_parser_core.sv
// Channel  Dir  Handshake               Payload
// req      in   req_tvalid/req_tready   tdata[7:0] char_code, tlast last_char
// rsp      out  rsp_tvalid/rsp_tready   tdata value, fail_pos; tuser parse_failed
// csr      in   csr_valid/csr_ready     csr_wdata[4:0] radix
//
// One byte is taken per cycle while req_tready is high; the multiply-add on
// the running value is the one path between the state registers and the
// result register. The result of the last byte is registered before it reaches rsp.
// A two-entry result buffer keeps req flowing while one result stalls;
// req_tready drops only when both entries are full.
// Synchronous reset clears the numeral state and sets radix to 10.
`default_nettype none

module ascii_integer_parser_core import aip_pkg::*; #(
   parameter int MAX_CHARS = 1024
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [7:0]         req_tdata,   // [7:0] char_code
   input  wire logic               req_tlast,   // last_char
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [79:0]             rsp_tdata,   // [63:0] value, [73:64] fail_pos, zeros
   output logic [0:0]              rsp_tuser,   // [0] parse_failed
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [RADIX_W-1:0] csr_wdata    // radix
);

   logic [RADIX_W-1:0] radix_ff, radix_in;
   logic    take;
   logic    res_valid;
   rsp_type res;
   rsp_type out_data;

   assign csr_ready = 1'b1;
   assign radix_in  = (csr_valid && csr_ready) ? csr_wdata : radix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else begin
         radix_ff <= radix_in;
      end
   end

   assign take = req_tvalid && req_tready;

   aip_accum #(
      .MAX_CHARS(MAX_CHARS)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .char_code (req_tdata),
      .last_char (req_tlast),
      .radix     (radix_ff),
      .rsp_valid (res_valid),
      .rsp       (res)
   );

   aip_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tdata = {6'b0, out_data.pos, out_data.value};
   assign rsp_tuser = out_data.failed;

endmodule

`default_nettype wire

>>> rtl/aip_accum.sv
`default_nettype none

module aip_accum import aip_pkg::*; #(
   parameter int MAX_CHARS = 1024
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               take,
   input  wire logic [CHAR_W-1:0]  char_code,
   input  wire logic               last_char,
   input  wire logic [RADIX_W-1:0] radix,
   output logic                    rsp_valid,
   output rsp_type                 rsp
);

   localparam int IDX_W = (MAX_CHARS > 2) ? $clog2(MAX_CHARS) : 1;
   localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_CHARS - 1);

   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               bad_ff, bad_in;
   logic [IDX_W-1:0]   bad_idx_ff, bad_idx_in;
   logic               nul_ff, nul_in;

   digit_type            dig;
   logic                 dig_ok;
   logic [VALUE_W+RADIX_W-1:0] prod;
   logic [VALUE_W-1:0]   acc_step;
   logic [IDX_W+POS_W-1:0] pos_ext;

   assign dig      = digit_of(char_code);
   assign dig_ok   = dig.hex && ({1'b0, dig.val} < radix);
   assign prod     = {{RADIX_W{1'b0}}, acc_ff} * {{VALUE_W{1'b0}}, radix};
   assign acc_step = prod[VALUE_W-1:0] + VALUE_W'(dig.val);

   // next state for the numeral, before the end-of-numeral clear
   logic [VALUE_W-1:0] acc_nx;
   logic [IDX_W-1:0]   idx_nx;
   logic               bad_nx;
   logic [IDX_W-1:0]   bad_idx_nx;
   logic               nul_nx;

   always_comb begin
      acc_nx     = acc_ff;
      idx_nx     = idx_ff;
      bad_nx     = bad_ff;
      bad_idx_nx = bad_idx_ff;
      nul_nx     = nul_ff;
      if (!nul_ff) begin
         if (char_code == CHAR_NUL) begin
            nul_nx = 1'b1;
         end else begin
            if (dig_ok) begin
               acc_nx = acc_step;
            end else begin
               bad_nx     = 1'b1;
               bad_idx_nx = idx_ff;
            end
            if (idx_ff != IDX_MAX) begin
               idx_nx = idx_ff + IDX_W'(1);
            end
         end
      end
   end

   always_comb begin
      acc_in     = acc_ff;
      idx_in     = idx_ff;
      bad_in     = bad_ff;
      bad_idx_in = bad_idx_ff;
      nul_in     = nul_ff;
      if (take) begin
         if (last_char) begin
            acc_in     = '0;
            idx_in     = '0;
            bad_in     = 1'b0;
            bad_idx_in = '0;
            nul_in     = 1'b0;
         end else begin
            acc_in     = acc_nx;
            idx_in     = idx_nx;
            bad_in     = bad_nx;
            bad_idx_in = bad_idx_nx;
            nul_in     = nul_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff     <= '0;
         idx_ff     <= '0;
         bad_ff     <= 1'b0;
         bad_idx_ff <= '0;
         nul_ff     <= 1'b0;
      end else begin
         acc_ff     <= acc_in;
         idx_ff     <= idx_in;
         bad_ff     <= bad_in;
         bad_idx_ff <= bad_idx_in;
         nul_ff     <= nul_in;
      end
   end

   // low bits of the position, zero filled when the counter is narrow
   assign pos_ext = {{POS_W{1'b0}}, bad_idx_nx};

   assign rsp_valid = take && last_char;
   assign rsp       = '{pos:    bad_nx ? pos_ext[POS_W-1:0] : {POS_W{1'b0}},
                        failed: bad_nx,
                        value:  bad_nx ? {VALUE_W{1'b0}} : acc_nx};

`ifndef SYNTH
   a_idx_sat: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= IDX_MAX)
      else $error("position counter beyond saturation");
   a_bad_idx_clean: assert property (@(posedge clock) disable iff (reset)
      !bad_ff |-> (bad_idx_ff == '0))
      else $error("failure position set without a failure");
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (take && last_char) |=> (acc_ff == '0 && !bad_ff && !nul_ff && idx_ff == '0))
      else $error("state not cleared after end of numeral");
`endif

endmodule

`default_nettype wire

>>> rtl/aip_rsp_buf.sv
`default_nettype none

module aip_rsp_buf import aip_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   input  wire rsp_type in_data,
   output logic         in_ready,
   output logic         out_valid,
   input  wire logic    out_ready,
   output rsp_type      out_data
);

   logic    main_valid_ff, main_valid_in;
   rsp_type main_ff, main_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_ff, skid_in;
   logic    pop;

   assign pop = main_valid_ff && out_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_in       = main_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || pop) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_in       = in_data;
            skid_valid_in = in_valid;
         end else begin
            main_in       = in_data;
            main_valid_in = in_valid;
         end
      end else if (in_valid) begin
         skid_in       = in_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

`ifndef SYNTH
   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry held while output empty");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> !skid_valid_ff)
      else $error("result pushed into full buffer");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (main_valid_ff && !out_ready) |=> (main_valid_ff && $stable(main_ff)))
      else $error("stalled result changed");
`endif

endmodule

`default_nettype wire
